/* hw/rtl/wbl_pkg.sv */
`default_nettype none

package wbl_pkg;

  // Buffer geometry.
  localparam int DEPTH    = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CAP_W    = 6;
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Field widths.
  localparam int ADDR_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 2;
  localparam int EIDX_W   = 6;
  localparam int TOTAL_W  = 32;

  // Input item kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] RES_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] RES_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] RES_FLUSH  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic emit_ack;
    logic emit_search;
    logic emit_flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_valid;
    logic req_kind;
    logic full;
    logic out_free;
    logic flush_last;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/wbl_in_if.sv */
`default_nettype none

interface wbl_in_if import wbl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ADDR_W-1:0]   block_address;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output kind, output block_address, output handle,
                  input ready);
  modport sink (input valid, input kind, input block_address, input handle,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/wbl_out_if.sv */
`default_nettype none

interface wbl_out_if import wbl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic                hit;
  logic [EIDX_W-1:0]   entry_index;
  logic [ADDR_W-1:0]   entry_address;
  logic [HANDLE_W-1:0] entry_handle;
  logic                last;
  logic [TOTAL_W-1:0]  hits_total;
  logic [TOTAL_W-1:0]  misses_total;

  modport source (output valid, output result_kind, output hit, output entry_index,
                  output entry_address, output entry_handle, output last,
                  output hits_total, output misses_total, input ready);
  modport sink (input valid, input result_kind, input hit, input entry_index,
                input entry_address, input entry_handle, input last,
                input hits_total, input misses_total, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wbl_cfg_if.sv */
`default_nettype none

interface wbl_cfg_if import wbl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wbl_ctrl.sv */
`default_nettype none

module wbl_ctrl import wbl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACK    = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_FLUSH  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (status.req_valid) begin
          if (status.req_kind == KIND_SEARCH) begin
            state_next = S_SEARCH;
          end else if (status.full) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_ACK;
          end
        end
      end
      S_ACK: begin
        if (status.out_free) begin
          cmd.emit_ack = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (status.out_free) begin
          cmd.emit_search = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_flush = 1'b1;
          if (status.flush_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wbl_datapath.sv */
`default_nettype none

module wbl_datapath import wbl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  wbl_in_if.sink    req,
  wbl_out_if.source rsp,
  wbl_cfg_if.sink   cfg,
  input  wire cmd_t cmd,
  output status_t   status
);

  logic [ADDR_W-1:0]   addr_mem [DEPTH];
  logic [HANDLE_W-1:0] hnd_mem  [DEPTH];
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    fill_inc;
  logic [CAP_W-1:0]    capacity;
  logic [CMP_W-1:0]    eff_cap;
  logic [DEPTH-1:0]    match;
  logic [IDX_W-1:0]    flush_idx;
  logic [TOTAL_W-1:0]  hits;
  logic [TOTAL_W-1:0]  misses;

  logic                found;
  logic [IDX_W-1:0]    where;
  logic [IDX_W-1:0]    rd_idx;
  logic                accept;
  logic                out_valid;

  assign accept   = req.valid && cmd.take;
  assign req.ready = cmd.take;
  assign cfg.ready = 1'b1;
  assign fill_inc  = fill + CNT_W'(1);

  // Capacity register; zero acts as one and anything above the depth as the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(DEPTH);
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  // Entry storage, written at the fill position by an insert.
  always_ff @(posedge clk) begin
    if (accept && (req.kind == KIND_INSERT) && (fill < CNT_W'(DEPTH))) begin
      addr_mem[fill[IDX_W-1:0]] <= req.block_address;
      hnd_mem[fill[IDX_W-1:0]]  <= req.handle;
    end
  end

  // Fill count and flush pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      flush_idx <= '0;
    end else begin
      if (accept && (req.kind == KIND_INSERT)) begin
        if (fill < CNT_W'(DEPTH)) begin
          fill <= fill_inc;
        end
        flush_idx <= '0;
      end else if (cmd.emit_flush) begin
        flush_idx <= flush_idx + IDX_W'(1);
        if (status.flush_last) begin
          fill <= '0;
        end
      end
    end
  end

  // Parallel address compare over the filled slots, registered.
  always_ff @(posedge clk) begin
    if (accept && (req.kind == KIND_SEARCH)) begin
      for (int i = 0; i < DEPTH; i++) begin
        match[i] <= (CNT_W'(i) < fill) && (addr_mem[i] == req.block_address);
      end
    end
  end

  // Newest match wins: the highest set slot.
  always_comb begin
    found = 1'b0;
    where = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        found = 1'b1;
        where = IDX_W'(i);
      end
    end
  end

  // One shared read port for flush and search.
  assign rd_idx = cmd.emit_flush ? flush_idx : where;

  // Hit and miss counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      misses <= '0;
    end else if (cmd.emit_search) begin
      if (found) begin
        hits <= hits + TOTAL_W'(1);
      end else begin
        misses <= misses + TOTAL_W'(1);
      end
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ack || cmd.emit_search || cmd.emit_flush) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      rsp.result_kind   <= RES_ACK;
      rsp.hit           <= 1'b0;
      rsp.entry_index   <= '0;
      rsp.entry_address <= '0;
      rsp.entry_handle  <= '0;
      rsp.last          <= 1'b1;
      rsp.hits_total    <= hits;
      rsp.misses_total  <= misses;
    end else if (cmd.emit_search) begin
      rsp.result_kind   <= RES_SEARCH;
      rsp.hit           <= found;
      rsp.last          <= 1'b1;
      if (found) begin
        rsp.entry_index   <= EIDX_W'(rd_idx);
        rsp.entry_address <= addr_mem[rd_idx];
        rsp.entry_handle  <= hnd_mem[rd_idx];
        rsp.hits_total    <= hits + TOTAL_W'(1);
        rsp.misses_total  <= misses;
      end else begin
        rsp.entry_index   <= '0;
        rsp.entry_address <= '0;
        rsp.entry_handle  <= '0;
        rsp.hits_total    <= hits;
        rsp.misses_total  <= misses + TOTAL_W'(1);
      end
    end else if (cmd.emit_flush) begin
      rsp.result_kind   <= RES_FLUSH;
      rsp.hit           <= 1'b0;
      rsp.entry_index   <= EIDX_W'(rd_idx);
      rsp.entry_address <= addr_mem[rd_idx];
      rsp.entry_handle  <= hnd_mem[rd_idx];
      rsp.last          <= status.flush_last;
      rsp.hits_total    <= hits;
      rsp.misses_total  <= misses;
    end
  end

  assign rsp.valid = out_valid;

  // Status towards the controller.
  always_comb begin
    status.req_valid  = req.valid;
    status.req_kind   = req.kind;
    status.full       = CMP_W'(fill_inc) >= eff_cap;
    status.out_free   = !out_valid || rsp.ready;
    status.flush_last = (CNT_W'(flush_idx) + CNT_W'(1)) == fill;
  end

endmodule

`default_nettype wire

/* hw/rtl/write_buffer_lookup_flush.sv */
// Insert: the ack state registers the acknowledge; one that fills the buffer starts a flush.
// Search: a registered compare of the filled slots, then the search state registers the answer.
// Flush: one entry per cycle out of the shared read port while the output is free, to the last.
// A waiting result in the output register does not hold off the next input beat, taken in idle.
// Synchronous active-high reset clears the fill count, both counters and the controller,
// and sets capacity to the depth; the entry storage is not cleared.
`default_nettype none

module write_buffer_lookup_flush import wbl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  wbl_in_if.sink    req,
  wbl_out_if.source rsp,
  wbl_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  wbl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Storage, compare, counters and output register.
  wbl_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

`default_nettype wire
